@@ sv/assert_macros.svh @@
// assertion helpers, sampled on the rising clock edge and off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// condition must never hold
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ sv/m3alu_pkg.sv @@
`default_nettype none

package m3alu_pkg;

	localparam int DATA_W = 32;
	localparam int ACT_W  = 3;

	typedef enum logic [ACT_W-1:0] {
		ACT_MUL = 3'd0,
		ACT_ADD = 3'd1,
		ACT_SUB = 3'd2,
		ACT_TRN = 3'd3,
		ACT_EQU = 3'd4
	} act_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ISSUE,
		ST_WAIT
	} st_t;

	// one step token sent from the sequencer into the datapath
	typedef struct packed {
		logic valid;
		logic first;
		logic last_step;
		logic last_elem;
	} issue_t;

endpackage

`default_nettype wire

@@ sv/matrix3_alu.sv @@
// matrix3_alu: MATRIX_DIM x MATRIX_DIM matrix unit, signed fixed point with
// FRACTION_BITS fraction bits (Q16.16 by default).
// input stream: one element per item, matrix A row-major, then matrix B
// row-major except for transpose. tuser of the first item of a set picks
// the action (0 mul, 1 add, 2 sub, 3 transpose, 4 equality); an unknown
// code on the first item drops that item.
// output stream: the result elements row-major with tlast on the final one,
// or a single item with tuser set when A equals B for the equality test.
// s_tready stays high while loading, so an element is taken whenever s_tvalid
// is high. after the last element s_tready stays low while one multiplier/adder
// works through the results: each output element is built from steps issued
// one after another, MATRIX_DIM for multiply, 1 for add, subtract and
// transpose, and MATRIX_DIM^2 for the one equality result.
// a finished result waits in the output register; the next one is computed
// behind it, and the unit stalls only when both are held by the receiver.
// reset clears the sequencer and the output valid; stored matrices are not
// cleared since every set rewrites them before use.
`default_nettype none
`include "assert_macros.svh"

module matrix3_alu #(
	parameter int MATRIX_DIM = 3,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] element_value
	input  wire logic [2:0]  s_tuser,   // [2:0] action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] result_value
	output logic [0:0]       m_tuser,   // [0] matrices_equal
	output logic             m_tlast
);

	localparam int CELLS  = MATRIX_DIM * MATRIX_DIM;
	localparam int CELL_W = $clog2(CELLS);

	m3alu_pkg::act_t   act;
	m3alu_pkg::issue_t iss;
	logic              drained, wr_en, wr_sel_b;
	logic [CELL_W-1:0] wr_addr, addr_a, addr_b;

	m3alu_seq #(
		.MATRIX_DIM(MATRIX_DIM)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.drained  (drained),
		.ready    (s_tready),
		.act      (act),
		.iss      (iss),
		.wr_en    (wr_en),
		.wr_sel_b (wr_sel_b),
		.wr_addr  (wr_addr),
		.addr_a   (addr_a),
		.addr_b   (addr_b)
	);

	m3alu_dp #(
		.MATRIX_DIM   (MATRIX_DIM),
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.act      (act),
		.iss      (iss),
		.addr_a   (addr_a),
		.addr_b   (addr_b),
		.wr_en    (wr_en),
		.wr_sel_b (wr_sel_b),
		.wr_addr  (wr_addr),
		.wr_data  (s_tdata),
		.drained  (drained),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	`ASSERT_NEVER(a_ready_while_busy, s_tready && !drained, "input ready while datapath busy")
	`ASSERT_NEVER(a_issue_while_load, iss.valid && s_tready, "step issued while loading")
	`ASSERT_IMPLY(a_equal_is_last, m_tvalid && m_tuser[0], m_tlast, "equality flag not on last item")

endmodule

`default_nettype wire

@@ sv/m3alu_seq.sv @@
`default_nettype none

module m3alu_seq #(
	parameter int MATRIX_DIM = 3,
	localparam int CELLS = MATRIX_DIM * MATRIX_DIM,
	localparam int CELL_W = $clog2(CELLS)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	input  wire logic [m3alu_pkg::ACT_W-1:0]   s_tuser,
	input  wire logic                          drained,
	output logic                               ready,
	output m3alu_pkg::act_t                    act,
	output m3alu_pkg::issue_t                  iss,
	output logic                               wr_en,
	output logic                               wr_sel_b,
	output logic [CELL_W-1:0]                  wr_addr,
	output logic [CELL_W-1:0]                  addr_a,
	output logic [CELL_W-1:0]                  addr_b
);

	localparam int IDX_W  = $clog2(MATRIX_DIM);
	localparam int LOAD_W = $clog2(2 * CELLS);
	localparam logic [CELL_W-1:0] DIM_C = CELL_W'(MATRIX_DIM);

	m3alu_pkg::st_t  state_q, state_d;
	m3alu_pkg::act_t held_q, act_now;
	logic [LOAD_W-1:0] load_q, need_last;
	logic [IDX_W-1:0]  row_q, col_q;
	logic [CELL_W-1:0] step_q, rowx, colx;
	logic accept, bad, load_done, last_step, last_elem;

	always_comb begin
		accept    = s_tvalid && ready;
		// unknown action code on the first item drops that item
		bad       = (load_q == '0) && (s_tuser > m3alu_pkg::ACT_EQU);
		act_now   = (load_q == '0) ? m3alu_pkg::act_t'(s_tuser) : held_q;
		need_last = (act_now == m3alu_pkg::ACT_TRN) ? LOAD_W'(CELLS - 1) : LOAD_W'(2 * CELLS - 1);
		load_done = accept && !bad && (load_q == need_last);
		case (held_q)
			m3alu_pkg::ACT_MUL: last_step = (step_q == CELL_W'(MATRIX_DIM - 1));
			m3alu_pkg::ACT_EQU: last_step = (step_q == CELL_W'(CELLS - 1));
			default:            last_step = 1'b1;
		endcase
		last_elem = (held_q == m3alu_pkg::ACT_EQU) ||
			((row_q == IDX_W'(MATRIX_DIM - 1)) && (col_q == IDX_W'(MATRIX_DIM - 1)));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			m3alu_pkg::ST_LOAD: begin
				if (load_done) state_d = m3alu_pkg::ST_ISSUE;
			end
			m3alu_pkg::ST_ISSUE: begin
				if (last_step) state_d = m3alu_pkg::ST_WAIT;
			end
			m3alu_pkg::ST_WAIT: begin
				if (drained) state_d = last_elem ? m3alu_pkg::ST_LOAD : m3alu_pkg::ST_ISSUE;
			end
			default: state_d = m3alu_pkg::ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		ready         = (state_q == m3alu_pkg::ST_LOAD);
		act           = held_q;
		iss.valid     = (state_q == m3alu_pkg::ST_ISSUE);
		iss.first     = (step_q == '0);
		iss.last_step = last_step;
		iss.last_elem = last_elem;
		wr_en         = accept && !bad;
		wr_sel_b      = (load_q >= LOAD_W'(CELLS));
		wr_addr       = wr_sel_b ? CELL_W'(load_q - LOAD_W'(CELLS)) : CELL_W'(load_q);
	end

	// read addresses for the current step
	always_comb begin
		rowx = CELL_W'(row_q);
		colx = CELL_W'(col_q);
		case (held_q)
			m3alu_pkg::ACT_MUL: begin
				addr_a = rowx * DIM_C + step_q;
				addr_b = step_q * DIM_C + colx;
			end
			m3alu_pkg::ACT_TRN: begin
				addr_a = colx * DIM_C + rowx;
				addr_b = colx * DIM_C + rowx;
			end
			m3alu_pkg::ACT_EQU: begin
				addr_a = step_q;
				addr_b = step_q;
			end
			default: begin
				addr_a = rowx * DIM_C + colx;
				addr_b = rowx * DIM_C + colx;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= m3alu_pkg::ST_LOAD;
			held_q  <= m3alu_pkg::ACT_MUL;
			load_q  <= '0;
			row_q   <= '0;
			col_q   <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept && !bad) begin
				if (load_q == '0) held_q <= m3alu_pkg::act_t'(s_tuser);
				load_q <= load_done ? '0 : load_q + LOAD_W'(1);
			end
			if (state_q == m3alu_pkg::ST_ISSUE) begin
				step_q <= last_step ? '0 : step_q + CELL_W'(1);
			end
			if ((state_q == m3alu_pkg::ST_WAIT) && drained && !last_elem) begin
				if (col_q == IDX_W'(MATRIX_DIM - 1)) begin
					col_q <= '0;
					row_q <= row_q + IDX_W'(1);
				end else begin
					col_q <= col_q + IDX_W'(1);
				end
			end
			if (load_done) begin
				row_q  <= '0;
				col_q  <= '0;
				step_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/m3alu_dp.sv @@
`default_nettype none

module m3alu_dp #(
	parameter int MATRIX_DIM = 3,
	parameter int FRACTION_BITS = 16,
	localparam int CELLS = MATRIX_DIM * MATRIX_DIM,
	localparam int CELL_W = $clog2(CELLS)
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire m3alu_pkg::act_t                    act,
	input  wire m3alu_pkg::issue_t                  iss,
	input  wire logic [CELL_W-1:0]                  addr_a,
	input  wire logic [CELL_W-1:0]                  addr_b,
	input  wire logic                               wr_en,
	input  wire logic                               wr_sel_b,
	input  wire logic [CELL_W-1:0]                  wr_addr,
	input  wire logic signed [m3alu_pkg::DATA_W-1:0] wr_data,
	output logic                                    drained,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [m3alu_pkg::DATA_W-1:0]            m_tdata,
	output logic [0:0]                              m_tuser,
	output logic                                    m_tlast
);

	localparam logic signed [63:0] MAX64 = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] MIN64 = {1'b1, {63{1'b0}}};

	logic signed [31:0] mem_a [CELLS];
	logic signed [31:0] mem_b [CELLS];

	m3alu_pkg::issue_t tok_s1, tok_s2;
	logic signed [31:0] a_s1, b_s1;
	logic signed [63:0] term_s2;
	logic               eq_s2;
	logic signed [63:0] acc_q, term, base, acc_next;
	logic        [64:0] sum65;
	logic               eq_q;
	logic               res_pending_q, res_last_q, out_valid_q, load_out;
	logic        [31:0] sat_val, out_data_q;
	logic               out_eq_q, out_last_q;

	function automatic logic signed [63:0] sext64(input logic signed [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	// operand stores and registered reads
	always_ff @(posedge clk) begin
		if (wr_en && !wr_sel_b) mem_a[wr_addr] <= wr_data;
		if (wr_en && wr_sel_b)  mem_b[wr_addr] <= wr_data;
		if (iss.valid) begin
			a_s1 <= mem_a[addr_a];
			b_s1 <= mem_b[addr_b];
		end
	end

	// shared unit: one multiplier, or the add / subtract / compare / transpose copy
	always_ff @(posedge clk) begin
		if (tok_s1.valid) begin
			eq_s2 <= (a_s1 == b_s1);
			case (act)
				m3alu_pkg::ACT_MUL: term_s2 <= a_s1 * b_s1;
				m3alu_pkg::ACT_ADD: term_s2 <= sext64(a_s1) + sext64(b_s1);
				m3alu_pkg::ACT_SUB: term_s2 <= sext64(a_s1) - sext64(b_s1);
				m3alu_pkg::ACT_TRN: term_s2 <= sext64(a_s1);
				default:            term_s2 <= '0;
			endcase
		end
	end

	// products round toward minus infinity, then a saturating 64-bit accumulate
	always_comb begin
		term  = (act == m3alu_pkg::ACT_MUL) ? (term_s2 >>> FRACTION_BITS) : term_s2;
		base  = tok_s2.first ? '0 : acc_q;
		sum65 = {base[63], base} + {term[63], term};
		if (sum65[64] != sum65[63]) acc_next = sum65[64] ? MIN64 : MAX64;
		else                        acc_next = sum65[63:0];
		if ((&acc_q[63:31]) || !(|acc_q[63:31])) sat_val = acc_q[31:0];
		else sat_val = acc_q[63] ? 32'h8000_0000 : 32'h7fff_ffff;
		load_out = res_pending_q && (!out_valid_q || m_tready);
		drained  = !tok_s1.valid && !tok_s2.valid && !res_pending_q;
	end

	always_ff @(posedge clk) begin
		if (tok_s2.valid) begin
			acc_q <= acc_next;
			eq_q  <= tok_s2.first ? eq_s2 : (eq_q && eq_s2);
			if (tok_s2.last_step) res_last_q <= tok_s2.last_elem;
		end
		if (load_out) begin
			out_data_q <= (act == m3alu_pkg::ACT_EQU) ? '0 : sat_val;
			out_eq_q   <= (act == m3alu_pkg::ACT_EQU) && eq_q;
			out_last_q <= res_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1        <= '0;
			tok_s2        <= '0;
			res_pending_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			tok_s1 <= iss;
			tok_s2 <= tok_s1;
			if (tok_s2.valid && tok_s2.last_step) res_pending_q <= 1'b1;
			else if (load_out)                    res_pending_q <= 1'b0;
			if (load_out)      out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_eq_q;
	assign m_tlast    = out_last_q;

endmodule

`default_nettype wire

@@ bench/tb_matrix3_alu.sv @@
`timescale 1ns / 100ps

module tb_matrix3_alu;

	localparam int DIM = 3;
	localparam int FRAC = 16;
	localparam int CELLS = DIM * DIM;
	localparam int ITEM_BUDGET = 370;
	localparam int QUIET_LIMIT = 3000;
	localparam int TAIL_CYCLES = 200;
	localparam logic [2:0] ACT_CODE_MAX = 3'b111;

	// mixes of element values used by the stimulus
	localparam int VAL_EXTREME = 0;
	localparam int VAL_SMALL = 1;
	localparam int VAL_WIDE = 2;
	localparam int VAL_MIXED = 3;

	class matrix3_scoreboard;
		typedef struct {
			logic [31:0] value;
			logic        equal;
			logic        last;
		} result_t;

		int              a_cells[CELLS];
		int              b_cells[CELLS];
		int              taken;
		m3alu_pkg::act_t op;
		result_t         awaited[$];
		int              errors;

		function new();
			taken = 0;
			op = m3alu_pkg::ACT_MUL;
			errors = 0;
		endfunction

		static function int clip32(longint v);
			if (v > longint'(32'sh7fff_ffff))
				return 32'sh7fff_ffff;
			if (v < -longint'(32'sh7fff_ffff) - 1)
				return 32'sh8000_0000;
			return int'(v);
		endfunction

		// note one accepted element, predicting the results of a completed set
		function void take_element(logic [2:0] code, logic [31:0] value);
			int      need;
			int      idx;
			longint  acc;
			result_t r;
			if (taken == 0) begin
				if (code > m3alu_pkg::ACT_EQU)
					return;
				op = m3alu_pkg::act_t'(code);
			end
			if (taken < CELLS)
				a_cells[taken] = value;
			else
				b_cells[taken - CELLS] = value;
			taken++;
			need = (op == m3alu_pkg::ACT_TRN) ? CELLS : 2 * CELLS;
			if (taken < need)
				return;
			taken = 0;
			if (op == m3alu_pkg::ACT_EQU) begin
				r.value = '0;
				r.equal = 1'b1;
				r.last = 1'b1;
				for (int i = 0; i < CELLS; i++)
					if (a_cells[i] != b_cells[i])
						r.equal = 1'b0;
				awaited.push_back(r);
				return;
			end
			for (int i = 0; i < DIM; i++) begin
				for (int j = 0; j < DIM; j++) begin
					idx = i * DIM + j;
					case (op)
						m3alu_pkg::ACT_MUL: begin
							acc = 0;
							// each product floored to the fraction before summing
							for (int k = 0; k < DIM; k++)
								acc += (longint'(a_cells[i * DIM + k]) *
									longint'(b_cells[k * DIM + j])) >>> FRAC;
							r.value = clip32(acc);
						end
						m3alu_pkg::ACT_ADD:
							r.value = clip32(longint'(a_cells[idx]) + longint'(b_cells[idx]));
						m3alu_pkg::ACT_SUB:
							r.value = clip32(longint'(a_cells[idx]) - longint'(b_cells[idx]));
						default: r.value = a_cells[j * DIM + i];
					endcase
					r.equal = 1'b0;
					r.last = (idx == CELLS - 1);
					awaited.push_back(r);
				end
			end
		endfunction

		function void check_result(logic [31:0] value, logic equal, logic last);
			result_t r;
			if (awaited.size() == 0) begin
				$error("unexpected result item: result_value %h", value);
				errors++;
				return;
			end
			r = awaited.pop_front();
			if (value !== r.value) begin
				$error("result_value: expected %h, got %h", r.value, value);
				errors++;
			end
			if (equal !== r.equal) begin
				$error("matrices_equal: expected %b, got %b", r.equal, equal);
				errors++;
			end
			if (last !== r.last) begin
				$error("last: expected %b, got %b", r.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;

	matrix3_scoreboard sb = new();
	int send_idle_pct = 28;
	int recv_idle_pct = 79;
	int items_sent = 0;
	int quiet_cycles = 0;

	matrix3_alu #(
		.MATRIX_DIM(DIM),
		.FRACTION_BITS(FRAC)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser[0], m_tlast);
	end

	always @(posedge clk) begin
		if (arst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] pick_value(int flavor);
		int f;
		f = (flavor == VAL_MIXED) ? $urandom_range(VAL_WIDE) : flavor;
		case (f)
			VAL_EXTREME: begin
				case ($urandom_range(6))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					3: return 32'hffff_ffff;
					4: return 32'h0001_0000;
					5: return 32'hffff_0000;
					default: return 32'h0000_0001;
				endcase
			end
			// a few units either side of zero, with fraction bits
			VAL_SMALL: return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
			default: return $urandom;
		endcase
	endfunction

	// entered and left at a falling edge; tvalid stays high after the item
	task automatic send_element(input logic [2:0] code, input logic [31:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tuser <= code;
		do
			@(posedge clk);
		while (!s_tready);
		sb.take_element(code, value);
		@(negedge clk);
	endtask

	task automatic send_set(input logic [2:0] op, input int flavor);
		logic [31:0] a_vals[CELLS];
		logic [31:0] v;
		logic [2:0]  code;
		int          n;
		bit          copy_a;
		int          diff_at;
		n = (op == m3alu_pkg::ACT_TRN) ? CELLS : 2 * CELLS;
		copy_a = (op == m3alu_pkg::ACT_EQU) && $urandom_range(1);
		diff_at = $urandom_range(CELLS);
		for (int i = 0; i < n; i++) begin
			if (i < CELLS) begin
				a_vals[i] = pick_value(flavor);
				v = a_vals[i];
			end else if (copy_a) begin
				v = a_vals[i - CELLS];
				if (i - CELLS == diff_at)
					v[$urandom_range(31)] ^= 1'b1;
			end else begin
				v = pick_value(flavor);
			end
			// action is ignored after the first item of a set
			code = (i == 0) ? op : 3'($urandom_range(ACT_CODE_MAX));
			send_element(code, v);
			items_sent++;
		end
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (sb.awaited.size() != 0);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// unknown action code on a first item is dropped
		send_element(ACT_CODE_MAX, 32'h1234_5678);
		// transpose of a matrix holding the extremes, every cell distinct
		for (int i = 0; i < CELLS; i++) begin
			send_element((i == 0) ? 3'(m3alu_pkg::ACT_TRN) : ACT_CODE_MAX,
				(i == 0) ? 32'h8000_0000 : (i == 1) ? 32'h7fff_ffff : 32'h1111_1111 * i);
			items_sent++;
		end
		send_set(m3alu_pkg::ACT_ADD, VAL_EXTREME);
		hold_until_drained();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 79 : 0;
			recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 28 : 0;
			while (items_sent < (phase + 1) * ITEM_BUDGET / 3) begin
				if ($urandom_range(9) == 0)
					send_element(3'($urandom_range(ACT_CODE_MAX, m3alu_pkg::ACT_EQU + 1)),
						$urandom);
				else
					send_set(3'($urandom_range(m3alu_pkg::ACT_EQU)), $urandom_range(VAL_MIXED));
				if ($urandom_range(7) == 0)
					hold_until_drained();
			end
			hold_until_drained();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.awaited.size() != 0) begin
			$error("%0d expected result items never arrived", sb.awaited.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/m3alu_pkg.sv
sv/m3alu_seq.sv
sv/m3alu_dp.sv
sv/matrix3_alu.sv
bench/tb_matrix3_alu.sv
